// ----- design/bst_pkg.sv -----
// shared constants and types for the box distance field sphere tracer
`default_nettype none

package bst_pkg;

   // trace limit
   localparam int MAX_STEPS = 20;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);

   // field widths
   localparam int COORD_W  = 32;
   localparam int DIR_W    = 18;
   localparam int BOX_W    = 23;
   localparam int THR_W    = 17;
   localparam int TRAVEL_W = 31;

   // internal arithmetic widths
   localparam int DIST_W   = 34;
   localparam int MUL_W    = 34;
   localparam int PROD_W   = 64;
   localparam int SQ_IN_W  = 64;
   localparam int SQ_OUT_W = 32;

   // stream payload widths
   localparam int REQ_W = 152;
   localparam int RSP_W = 128;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_THRESHOLD = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = 17'd66;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIR_W-1:0]   dir_type;

endpackage

`default_nettype wire

// ----- design/box_sdf_sphere_tracer.sv -----
// sphere tracer of a box distance field, sequencer and datapath
// each trace step passes edge, square, sum, root, and per-axis multiply and update states, the root
// in the 1-bit-per-cycle square root unit; up to MAX_STEPS steps, then a hit computes the travel, a miss outputs
// throughput: one ray at a time; the next request is taken the cycle after
// the result is loaded into the output register
// reset: synchronous, clears sequencer and output valid, box extents to zero, threshold 66
`default_nettype none

module box_sdf_sphere_tracer (
   input  wire                                  clock,
   input  wire                                  reset,
   // start_x, start_y, start_z, dir_x, dir_y, dir_z, zero pad
   input  wire  logic [bst_pkg::REQ_W-1:0]      req_tdata,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // hit, travel, tip_x, tip_y, tip_z
   output logic [bst_pkg::RSP_W-1:0]            rsp_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire                                  csr_we,
   input  wire  logic [bst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire  logic [bst_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = bst_pkg::COORD_W;
   localparam int DW = bst_pkg::DIST_W;
   localparam int SW = bst_pkg::STEP_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EDGE  = 4'd1;
   localparam logic [3:0] ST_SQX   = 4'd2;
   localparam logic [3:0] ST_SQY   = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_ROOT  = 4'd5;
   localparam logic [3:0] ST_MUL   = 4'd6;
   localparam logic [3:0] ST_UPD   = 4'd7;
   localparam logic [3:0] ST_CHECK = 4'd8;
   localparam logic [3:0] ST_TMUL  = 4'd9;
   localparam logic [3:0] ST_TACC  = 4'd10;
   localparam logic [3:0] ST_TROOT = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // configuration registers
   logic [bst_pkg::BOX_W-1:0] box_length_ff, box_length_in;
   logic [bst_pkg::BOX_W-1:0] box_width_ff, box_width_in;
   logic [bst_pkg::THR_W-1:0] hit_threshold_ff, hit_threshold_in;

   // sequencer and ray state
   logic [3:0]                state_ff, state_in;
   logic [1:0]                axis_ff, axis_in;
   logic [SW-1:0]             step_ff, step_in;
   bst_pkg::coord_type        t_ff [3];
   bst_pkg::coord_type        t_in [3];
   bst_pkg::coord_type        s_ff [3];
   bst_pkg::coord_type        s_in [3];
   bst_pkg::dir_type          dir_ff [3];
   bst_pkg::dir_type          dir_in [3];
   logic [CW-1:0]             px_ff, px_in;
   logic [CW-1:0]             py_ff, py_in;
   logic signed [DW-1:0]      neg_ff, neg_in;
   logic signed [DW-1:0]      dist_ff, dist_in;
   logic [bst_pkg::SQ_IN_W-1:0] acc_ff, acc_in;
   logic                      sat_ff, sat_in;
   logic                      hit_ff, hit_in;
   logic [bst_pkg::TRAVEL_W-1:0] travel_ff, travel_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bst_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [bst_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [bst_pkg::PROD_W-1:0] prod;
   logic                              sqrt_start;
   logic [bst_pkg::SQ_IN_W-1:0]       sqrt_op;
   logic                              sqrt_done;
   logic [bst_pkg::SQ_OUT_W-1:0]      sqrt_root;

   // combinational datapath
   logic [CW:0]               ax, ay;
   logic signed [DW-1:0]      sx, sy, mx;
   logic signed [bst_pkg::PROD_W-1:0] rnd;
   logic signed [CW+3:0]      t_sum;
   bst_pkg::coord_type        t_sat;
   logic [DW-1:0]             dabs;
   logic signed [CW:0]        dfs;
   logic [CW:0]               dfa;
   logic                      df_big;

   bst_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   bst_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_op),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // edge excess of the tip against the half extents
   assign ax = t_ff[0][CW-1] ? ((CW+1)'(0) - {t_ff[0][CW-1], t_ff[0]})
                             : {t_ff[0][CW-1], t_ff[0]};
   assign ay = t_ff[1][CW-1] ? ((CW+1)'(0) - {t_ff[1][CW-1], t_ff[1]})
                             : {t_ff[1][CW-1], t_ff[1]};
   assign sx = signed'({1'b0, ax}) - signed'({12'd0, box_length_ff[bst_pkg::BOX_W-1:1]});
   assign sy = signed'({1'b0, ay}) - signed'({12'd0, box_width_ff[bst_pkg::BOX_W-1:1]});
   assign mx = (sx > sy) ? sx : sy;

   // rounded advance and saturation of the selected tip component
   assign rnd   = prod + 64'sd32768;
   assign t_sum = signed'({{4{t_ff[axis_ff][CW-1]}}, t_ff[axis_ff]}) + rnd[CW+19:16];
   always_comb begin
      if (t_sum[CW+3:CW-1] == '0 || t_sum[CW+3:CW-1] == '1) begin
         t_sat = t_sum[CW-1:0];
      end else if (t_sum[CW+3]) begin
         t_sat = {1'b1, {(CW-1){1'b0}}};
      end else begin
         t_sat = {1'b0, {(CW-1){1'b1}}};
      end
   end

   // magnitude of the distance for the hit test
   assign dabs = dist_ff[DW-1] ? (DW'(0) - dist_ff) : dist_ff;

   // coordinate difference for the travel length
   assign dfs    = signed'({t_ff[axis_ff][CW-1], t_ff[axis_ff]})
                 - signed'({s_ff[axis_ff][CW-1], s_ff[axis_ff]});
   assign dfa    = dfs[CW] ? ((CW+1)'(0) - dfs) : dfs;
   assign df_big = (dfa[CW:CW-1] != 2'b00);

   // multiplier operand selection
   always_comb begin
      case (state_ff)
         ST_SQX: begin
            mul_a = signed'({2'b00, px_ff});
            mul_b = signed'({2'b00, px_ff});
         end
         ST_SQY: begin
            mul_a = signed'({2'b00, py_ff});
            mul_b = signed'({2'b00, py_ff});
         end
         ST_TMUL: begin
            mul_a = signed'({3'b000, dfa[CW-2:0]});
            mul_b = signed'({3'b000, dfa[CW-2:0]});
         end
         default: begin
            mul_a = dist_ff;
            mul_b = signed'({{(bst_pkg::MUL_W-bst_pkg::DIR_W){dir_ff[axis_ff][bst_pkg::DIR_W-1]}},
                             dir_ff[axis_ff]});
         end
      endcase
   end

   assign sqrt_op    = acc_ff + prod;
   assign sqrt_start = (state_ff == ST_SUM) ||
                       (state_ff == ST_TACC && axis_ff == AXIS_Z && !sat_ff);

   // configuration writes
   always_comb begin
      box_length_in    = box_length_ff;
      box_width_in     = box_width_ff;
      hit_threshold_in = hit_threshold_ff;
      if (csr_we) begin
         case (csr_index)
            bst_pkg::CSR_BOX_LENGTH:    box_length_in    = csr_wdata;
            bst_pkg::CSR_BOX_WIDTH:     box_width_in     = csr_wdata;
            bst_pkg::CSR_HIT_THRESHOLD: hit_threshold_in = csr_wdata[bst_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // trace sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      step_in      = step_ff;
      t_in         = t_ff;
      s_in         = s_ff;
      dir_in       = dir_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      neg_in       = neg_ff;
      dist_in      = dist_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      hit_in       = hit_ff;
      travel_in    = travel_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               s_in[0]   = req_tdata[31:0];
               s_in[1]   = req_tdata[63:32];
               s_in[2]   = req_tdata[95:64];
               t_in[0]   = req_tdata[31:0];
               t_in[1]   = req_tdata[63:32];
               t_in[2]   = req_tdata[95:64];
               dir_in[0] = req_tdata[113:96];
               dir_in[1] = req_tdata[131:114];
               dir_in[2] = req_tdata[149:132];
               step_in   = '0;
               state_in  = ST_EDGE;
            end
         end
         ST_EDGE: begin
            px_in    = (!sx[DW-1] && sx != '0) ? sx[CW-1:0] : '0;
            py_in    = (!sy[DW-1] && sy != '0) ? sy[CW-1:0] : '0;
            neg_in   = mx[DW-1] ? mx : '0;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            state_in = ST_SQY;
         end
         ST_SQY: begin
            acc_in   = prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               dist_in  = signed'({2'b00, sqrt_root}) + neg_ff;
               axis_in  = AXIS_X;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            t_in[axis_ff] = t_sat;
            if (axis_ff == AXIS_Z) begin
               state_in = ST_CHECK;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            if (dabs < {{(DW-bst_pkg::THR_W){1'b0}}, hit_threshold_ff}) begin
               hit_in   = 1'b1;
               axis_in  = AXIS_X;
               acc_in   = '0;
               sat_in   = 1'b0;
               state_in = ST_TMUL;
            end else if (step_ff == SW'(bst_pkg::MAX_STEPS - 1)) begin
               hit_in    = 1'b0;
               travel_in = '0;
               state_in  = ST_OUT;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_EDGE;
            end
         end
         ST_TMUL: begin
            sat_in   = sat_ff | df_big;
            state_in = ST_TACC;
         end
         ST_TACC: begin
            acc_in = acc_ff + prod;
            if (axis_ff == AXIS_Z) begin
               if (sat_ff) begin
                  travel_in = '1;
                  state_in  = ST_OUT;
               end else begin
                  state_in = ST_TROOT;
               end
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_TMUL;
            end
         end
         ST_TROOT: begin
            if (sqrt_done) begin
               travel_in = sqrt_root[bst_pkg::SQ_OUT_W-1] ? '1
                                                          : sqrt_root[bst_pkg::TRAVEL_W-1:0];
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (hit_ff) begin
                  rsp_data_in = {t_ff[2], t_ff[1], t_ff[0], travel_ff, 1'b1};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         box_length_ff    <= '0;
         box_width_ff     <= '0;
         hit_threshold_ff <= bst_pkg::THR_RESET;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         box_length_ff    <= box_length_in;
         box_width_ff     <= box_width_in;
         hit_threshold_ff <= hit_threshold_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      step_ff     <= step_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      dir_ff      <= dir_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      neg_ff      <= neg_in;
      dist_ff     <= dist_in;
      acc_ff      <= acc_in;
      sat_ff      <= sat_in;
      hit_ff      <= hit_in;
      travel_ff   <= travel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/bst_mul.sv -----
// registered signed multiplier shared by all products of the tracer
`default_nettype none

module bst_mul (
   input  wire                                 clock,
   input  wire  logic signed [bst_pkg::MUL_W-1:0]  op_a,
   input  wire  logic signed [bst_pkg::MUL_W-1:0]  op_b,
   output logic signed [bst_pkg::PROD_W-1:0]       prod
);

   logic signed [2*bst_pkg::MUL_W-1:0] full_w;
   logic signed [bst_pkg::PROD_W-1:0]  prod_ff;
   logic signed [bst_pkg::PROD_W-1:0]  prod_in;

   // full product, low bits kept (all used values fit)
   assign full_w  = op_a * op_b;
   assign prod_in = full_w[bst_pkg::PROD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ----- design/bst_sqrt.sv -----
// iterative floor square root, one result bit per cycle
`default_nettype none

module bst_sqrt (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   input  wire  logic [bst_pkg::SQ_IN_W-1:0]   radicand,
   output logic                                done,
   output logic [bst_pkg::SQ_OUT_W-1:0]        root
);

   localparam int CNT_W = $clog2(bst_pkg::SQ_OUT_W);
   localparam int REM_W = bst_pkg::SQ_OUT_W + 2;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [bst_pkg::SQ_IN_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]                rem_ff, rem_in;
   logic [bst_pkg::SQ_OUT_W-1:0]    root_ff, root_in;

   logic [REM_W+1:0]                rem_sh;
   logic [REM_W+1:0]                trial;
   logic [REM_W+1:0]                diff;

   // one digit step of the restoring square root
   assign rem_sh = {rem_ff, rad_ff[bst_pkg::SQ_IN_W-1 -: 2]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign diff   = rem_sh - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[bst_pkg::SQ_IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[bst_pkg::SQ_OUT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[bst_pkg::SQ_OUT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(bst_pkg::SQ_OUT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// ----- tb/box_sdf_sphere_tracer_checker.sv -----
// response checker for the box distance field sphere tracer: predicts and compares every ray
`timescale 1ns / 100ps

module box_sdf_sphere_tracer_checker
   import bst_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire [REQ_W-1:0]       req_tdata,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire [RSP_W-1:0]       rsp_tdata,
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire                   csr_we,
   input  wire [CSR_IDX_W-1:0]   csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_wdata,
   output int                    errors,
   output int                    outstanding,
   output int                    rays_done,
   output int                    hits_seen
);

   localparam longint COORD_MAX = 64'sh7FFF_FFFF;
   localparam longint COORD_MIN = -64'sh8000_0000;
   localparam longint unsigned TRAVEL_MAX = 64'h7FFF_FFFF;
   localparam int REPORT_LIMIT = 10;

   // one traced ray as it leaves the block, hit in bit 0
   typedef struct packed {
      coord_type             tip_z;
      coord_type             tip_y;
      coord_type             tip_x;
      logic [TRAVEL_W-1:0]   travel;
      logic                  hit;
   } ray_outcome_type;

   // shadow copy of the registers
   logic [BOX_W-1:0] box_len;
   logic [BOX_W-1:0] box_wid;
   logic [THR_W-1:0] hit_thr;

   ray_outcome_type expected_rays[$];
   ray_outcome_type want;
   ray_outcome_type got;

   // floor square root, one result bit per pass
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned rem, acc, probe;
      rem   = v;
      acc   = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= acc + probe) begin
            rem = rem - acc - probe;
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      return acc;
   endfunction

   // signed distance to the box, unbounded along z
   function automatic longint box_distance(longint px, longint py);
      longint ex, ey, ox, oy, worst, outside;
      ex = (px < 0 ? -px : px) - longint'(box_len >> 1);
      ey = (py < 0 ? -py : py) - longint'(box_wid >> 1);
      ox = ex > 0 ? ex : 0;
      oy = ey > 0 ? ey : 0;
      outside = longint'(root_floor(longint'(ox * ox) + longint'(oy * oy)));
      worst = ex > ey ? ex : ey;
      return outside + (worst < 0 ? worst : 0);
   endfunction

   // march one ray and measure how far the tip went
   function automatic ray_outcome_type trace_ray(logic [REQ_W-1:0] ray);
      longint org[3], tip[3], dir[3];
      longint step_len, moved;
      longint unsigned sq;
      bit reached, wide;
      int step, i;
      ray_outcome_type res;
      for (i = 0; i < 3; i++) begin
         org[i] = longint'($signed(ray[i*COORD_W +: COORD_W]));
         dir[i] = longint'($signed(ray[3*COORD_W + i*DIR_W +: DIR_W]));
         tip[i] = org[i];
      end
      reached = 1'b0;
      for (step = 0; step < MAX_STEPS && !reached; step++) begin
         step_len = box_distance(tip[0], tip[1]);
         // advance rounded half up, tip saturated each step
         for (i = 0; i < 3; i++) begin
            moved = tip[i] + ((step_len * dir[i] + 32768) >>> 16);
            tip[i] = moved > COORD_MAX ? COORD_MAX : (moved < COORD_MIN ? COORD_MIN : moved);
         end
         if ((step_len < 0 ? -step_len : step_len) < longint'(hit_thr)) reached = 1'b1;
      end
      res = '0;
      if (reached) begin
         sq = 0;
         wide = 1'b0;
         for (i = 0; i < 3; i++) begin
            moved = tip[i] - org[i];
            if (moved < 0) moved = -moved;
            if (moved >= 64'sh8000_0000) wide = 1'b1;
            else sq = sq + longint'(moved * moved);
         end
         sq = wide ? TRAVEL_MAX : root_floor(sq);
         if (sq > TRAVEL_MAX) sq = TRAVEL_MAX;
         res.hit    = 1'b1;
         res.travel = sq[TRAVEL_W-1:0];
         res.tip_x  = 32'(tip[0]);
         res.tip_y  = 32'(tip[1]);
         res.tip_z  = 32'(tip[2]);
      end
      return res;
   endfunction

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         box_len = '0;
         box_wid = '0;
         hit_thr = THR_RESET;
         expected_rays.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BOX_LENGTH:    box_len = csr_wdata[BOX_W-1:0];
               CSR_BOX_WIDTH:     box_wid = csr_wdata[BOX_W-1:0];
               CSR_HIT_THRESHOLD: hit_thr = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         // responses first: they belong to older requests
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            rays_done++;
            if (expected_rays.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response with no request pending: hit=%0d travel=%h tip=(%h %h %h)",
                           $realtime, got.hit, got.travel, got.tip_x, got.tip_y, got.tip_z);
            end else begin
               want = expected_rays.pop_front();
               if (want.hit) hits_seen++;
               if (got.hit !== want.hit || got.travel !== want.travel ||
                   got.tip_x !== want.tip_x || got.tip_y !== want.tip_y ||
                   got.tip_z !== want.tip_z) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: ray %0d mismatch", $realtime, rays_done);
                     $display("   expected hit=%0d travel=%h tip=(%h %h %h)",
                              want.hit, want.travel, want.tip_x, want.tip_y, want.tip_z);
                     $display("   actual   hit=%0d travel=%h tip=(%h %h %h)",
                              got.hit, got.travel, got.tip_x, got.tip_y, got.tip_z);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) expected_rays = {expected_rays, trace_ray(req_tdata)};
      end
      outstanding = expected_rays.size();
   end

endmodule

// ----- tb/tb_box_sdf_sphere_tracer.sv -----
// top of the sphere tracer testbench: clock, reset, ray requests, register phases, verdict
`timescale 1ns / 100ps

module tb_box_sdf_sphere_tracer;
   import bst_pkg::*;

   localparam int M = 65536;                 // one metre in Q16.16
   localparam int RANDOM_RAYS = 2000;
   localparam int RANDOM_PHASES = 8;
   localparam int PRESSURE_AT = 150;
   localparam int PRESSURE_CYCLES = 2000;
   localparam int TAIL_CYCLES = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_W-1:0]      req_tdata = '0;   // start_x, start_y, start_z, dir_x, dir_y, dir_z, pad
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_W-1:0]      rsp_tdata;        // hit, travel, tip_x, tip_y, tip_z
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int errors, outstanding, rays_done, hits_seen;
   int rays_sent = 0;
   int settings = 0;
   int cur_len = 0;
   int cur_wid = 0;
   bit burst = 1'b0;

   logic rsp_took = 1'b0;
   int   rsp_taken = 0;
   int   rsp_hold = 0;

   logic [REQ_W-1:0] probe[14];

   box_sdf_sphere_tracer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   box_sdf_sphere_tracer_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .errors      (errors),
      .outstanding (outstanding),
      .rays_done   (rays_done),
      .hits_seen   (hits_seen)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: random hold-off per response, one long stall to back up the block
   always @(posedge clock) rsp_took <= rsp_tvalid && rsp_tready;

   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_taken++;
         if (rsp_taken == PRESSURE_AT) rsp_hold = PRESSURE_CYCLES;
         else rsp_hold = burst ? 0 : $urandom_range(0, 5);
      end
      if (reset || rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         if (rsp_hold > 0) rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // pack one ray request, direction components cut to 18 bits
   function automatic logic [REQ_W-1:0] make_ray(int sx, int sy, int sz, int dx, int dy, int dz);
      logic [DIR_W-1:0] ex, ey, ez;
      ex = dx[DIR_W-1:0];
      ey = dy[DIR_W-1:0];
      ez = dz[DIR_W-1:0];
      return {2'b00, ez, ey, ex, sz, sy, sx};
   endfunction

   // ray from a point in metres along a normalized direction
   function automatic logic [REQ_W-1:0] unit_ray(real px, real py, real pz,
                                                 real vx, real vy, real vz);
      real span;
      span = $sqrt(vx * vx + vy * vy + vz * vz);
      if (span < 1.0e-9) begin
         vx = 1.0;
         span = 1.0;
      end
      return make_ray($rtoi(px * 65536.0), $rtoi(py * 65536.0), $rtoi(pz * 65536.0),
                      $rtoi(vx / span * 65536.0), $rtoi(vy / span * 65536.0),
                      $rtoi(vz / span * 65536.0));
   endfunction

   // uniform in -span .. span
   function automatic real spread(real span);
      return (real'($urandom_range(0, 2000000)) / 1000000.0 - 1.0) * span;
   endfunction

   // offer one request after a random gap and hold it until taken
   task automatic send_ray(logic [REQ_W-1:0] ray);
      int gap, i;
      gap = burst ? 0 : $urandom_range(0, 5);
      for (i = 0; i < gap; i++) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= ray;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      rays_sent++;
   endtask

   // one register write, enable dropped the next cycle
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_cfg(int len, int wid, logic [CSR_DATA_W-1:0] thr_word);
      write_reg(CSR_BOX_LENGTH, len[CSR_DATA_W-1:0]);
      write_reg(CSR_BOX_WIDTH, wid[CSR_DATA_W-1:0]);
      write_reg(CSR_HIT_THRESHOLD, thr_word);
      cur_len = len;
      cur_wid = wid;
      settings++;
   endtask

   // stop offering, then wait until every traced ray has come back
   task automatic drain;
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // random ray: mostly aimed at the box, some axis rays, far rays and raw noise
   task automatic send_random;
      int pick, axis, sgn;
      real hl, hw, px, py;
      logic [REQ_W-1:0] ray;
      pick = $urandom_range(0, 99);
      hl = real'(cur_len) / 131072.0;
      hw = real'(cur_wid) / 131072.0;
      px = spread(hl + 20.0);
      py = spread(hw + 20.0);
      if (pick < 65) begin
         ray = unit_ray(px, py, spread(1000.0), spread(hl) - px, spread(hw) - py, spread(3.0));
      end else if (pick < 80) begin
         axis = $urandom_range(0, 2);
         sgn  = $urandom_range(0, 1) ? M : -M;
         ray = make_ray($rtoi(px * 65536.0), $rtoi(py * 65536.0), $urandom,
                        axis == 0 ? sgn : 0, axis == 1 ? sgn : 0, axis == 2 ? sgn : 0);
      end else if (pick < 90) begin
         ray = unit_ray(spread(30000.0), spread(30000.0), spread(30000.0),
                        spread(1.0), spread(1.0), spread(1.0));
      end else begin
         ray = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      send_ray(ray);
   endtask

   initial begin
      int phase, n, thr;
      logic [CSR_DATA_W-1:0] thr_word;

      // hand-picked rays against a 4 m by 2 m box
      probe[0]  = make_ray(5*M, 0, 0, -M, 0, 0);
      probe[1]  = make_ray(0, -5*M, 3*M, 0, M, 0);
      probe[2]  = make_ray(0, 0, 0, M, 0, 0);                   // start inside the box
      probe[3]  = make_ray(2*M, 0, 0, 0, 0, 0);                 // on the surface, no direction
      probe[4]  = make_ray(10*M, 10*M, 0, -46341, -46341, 0);   // toward a corner
      probe[5]  = make_ray(5*M, 0, 0, M, 0, 0);                 // pointing away
      probe[6]  = make_ray(5*M, 0, 0, -131072, 0, 0);           // most negative direction code
      probe[7]  = make_ray(5*M, 0, 0, 131071, 131071, 131071);  // largest direction codes
      probe[8]  = make_ray(32'h8000_0000, 0, 0, M, 0, 0);
      probe[9]  = make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, -M, -M, M);
      probe[10] = make_ray(32'h8000_0000, 0, 32'h8000_0000, M, 0, M);       // root too large
      probe[11] = make_ray(32'h8000_0000, 0, 32'h8000_0000, M, 0, 131071);  // tip saturates
      probe[12] = make_ray(3*M, 3*M/2, -7*M, -40000, -20000, 45000);  // oblique, not unit
      probe[13] = make_ray(M/2, M/4, 0, 0, M, 0);

      // reset
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rays
      write_cfg(4*M, 2*M, 23'd66);
      for (n = 0; n < 14; n++) send_ray(probe[n]);
      drain;

      // zero threshold: nothing can hit
      write_cfg(4*M, 2*M, 23'd0);
      send_ray(probe[0]);
      send_ray(probe[4]);
      drain;

      // widest box codes, a one-metre threshold, then a write to the unused index
      write_cfg(23'h7F_FFFF, 23'h7F_FFFF, 23'd65536);
      write_reg(CSR_UNMAPPED, 23'h7F_FFFF);
      send_ray(probe[0]);
      send_ray(probe[8]);
      send_ray(probe[9]);
      drain;

      // odd extents, smallest nonzero threshold
      write_cfg(2*M + 1, M + 1, 23'd1);
      send_ray(probe[0]);
      send_ray(probe[2]);
      send_ray(probe[4]);
      drain;

      // degenerate box at the reset threshold
      write_cfg(0, 0, 23'd66);
      send_ray(probe[4]);
      send_ray(probe[12]);
      drain;

      // random phases, each with its own box and threshold
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         burst = 1'b0;
         if (phase == 0) begin
            write_cfg(6553600, 6553600, 23'd65536);
         end else if (phase == 1) begin
            write_cfg(0, 0, 23'd1);
         end else begin
            thr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65536)
                                              : $urandom_range(1, 400);
            thr_word = {6'($urandom_range(0, 63)), 17'(thr)};
            write_cfg($urandom_range(0, 6553600), $urandom_range(0, 6553600), thr_word);
         end
         burst = ($urandom_range(0, 3) == 0);
         for (n = 0; n < RANDOM_RAYS / RANDOM_PHASES; n++) send_random;
         drain;
      end

      // let any stray response show up
      burst = 1'b0;
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("traced %0d rays (%0d hits) over %0d register settings", rays_sent, hits_seen,
               settings);
      $display("%0d responses checked, %0d mismatches", rays_done, errors);
      if (errors == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/bst_pkg.sv
design/bst_mul.sv
design/bst_sqrt.sv
design/box_sdf_sphere_tracer.sv
tb/box_sdf_sphere_tracer_checker.sv
tb/tb_box_sdf_sphere_tracer.sv
